// ===== src/pfsk_pkg.sv =====
// Shared types, constants and fixed-point helpers for the phase-field stress kernel.
package pfsk_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned SatW    = ProdW - FracW;
  localparam int unsigned AccW    = 40;
  localparam int unsigned NStage  = 5;
  localparam int unsigned NPair   = 6;
  localparam int unsigned CfgIdxW = 2;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_A     = 2'd0,
    CFG_COEF_B     = 2'd1,
    CFG_COEF_KAPPA = 2'd2,
    CFG_COEF_C     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [NStage-1:0] en;
  } pipe_ctl_t;

  // Tensor entry order: xx, xy, xz, yy, yz, zz.
  localparam logic [1:0] PairI [NPair] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PairJ [NPair] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam int unsigned PairXX = 0;
  localparam int unsigned PairXY = 1;
  localparam int unsigned PairXZ = 2;
  localparam int unsigned PairYY = 3;
  localparam int unsigned PairYZ = 4;
  localparam int unsigned PairZZ = 5;
  localparam logic [NPair-1:0] PairDiag = 6'b101001;

  localparam logic signed [ProdW-1:0] QRnd   = ProdW'(1) << (FracW - 1);
  localparam acc_t                    FinRnd = AccW'(2);
  localparam int unsigned             QtrShift = 2;

  // Clamp a wide signed value to the Q16.16 range.
  function automatic q_t sat_q(input logic signed [SatW-1:0] v);
    q_t r;
    if (!v[SatW-1] && (|v[SatW-2:DataW-1])) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v[SatW-1] && !(&v[SatW-2:DataW-1])) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // Q16.16 product: exact, round half up, floor shift, saturate.
  function automatic q_t qmul(input q_t x, input q_t y);
    logic signed [ProdW-1:0] p;
    p = x * y;
    p = p + QRnd;
    return sat_q(p[ProdW-1:FracW]);
  endfunction

  function automatic acc_t ext_acc(input q_t t);
    return AccW'(t);
  endfunction

  // Quarter-LSB accumulator back to Q16.16.
  function automatic q_t finish(input acc_t acc);
    acc_t t;
    t = (acc + FinRnd) >>> QtrShift;
    return sat_q(SatW'(t));
  endfunction

endpackage

// ===== src/pfsk_core.sv =====
// Five-stage datapath: products, second-order products, coefficient scaling, sums, rounding.
module pfsk_core (
  input  logic                clk,
  input  pfsk_pkg::pipe_ctl_t ctl,
  input  pfsk_pkg::q_t        coef_a,
  input  pfsk_pkg::q_t        coef_b,
  input  pfsk_pkg::q_t        coef_kappa,
  input  pfsk_pkg::q_t        coef_c,
  input  pfsk_pkg::q_t        phi,
  input  pfsk_pkg::q_t        grad_x,
  input  pfsk_pkg::q_t        grad_y,
  input  pfsk_pkg::q_t        grad_z,
  input  pfsk_pkg::q_t        lap,
  input  pfsk_pkg::q_t        bilap,
  input  pfsk_pkg::q_t        glap_x,
  input  pfsk_pkg::q_t        glap_y,
  input  pfsk_pkg::q_t        glap_z,
  output pfsk_pkg::q_t        energy,
  output pfsk_pkg::q_t        chem_pot,
  output pfsk_pkg::q_t        pressure,
  output pfsk_pkg::q_t        s_xx,
  output pfsk_pkg::q_t        s_xy,
  output pfsk_pkg::q_t        s_xz,
  output pfsk_pkg::q_t        s_yy,
  output pfsk_pkg::q_t        s_yz,
  output pfsk_pkg::q_t        s_zz
);
  import pfsk_pkg::*;

  q_t g  [3];
  q_t gl [3];

  // stage 1
  q_t s1_phi_r, s1_phi2_r, s1_plap_r, s1_pbil_r, s1_lap2_r;
  q_t s1_aphi_r, s1_klap_r, s1_cbil_r;
  q_t s1_gg_r  [NPair];
  q_t s1_ggl_r [3][3];
  // stage 2
  q_t s2_phi3_r, s2_phi4_r, s2_g2_r, s2_ggl_r;
  q_t s2_aphi_r, s2_klap_r, s2_cbil_r;
  q_t s2_aphi2_r, s2_kplap_r, s2_cpbil_r, s2_clap2_r;
  q_t s2_pair_r [NPair];
  q_t s2_kgg_r  [NPair];
  // stage 3
  q_t s3_bphi3_r, s3_bphi4_r, s3_kg2_r, s3_cggl_r;
  q_t s3_aphi_r, s3_klap_r, s3_cbil_r;
  q_t s3_aphi2_r, s3_kplap_r, s3_cpbil_r, s3_clap2_r;
  q_t s3_cpair_r [NPair];
  q_t s3_kgg_r   [NPair];
  // stage 4
  acc_t s4_e_r, s4_mu_r, s4_p_r;
  acc_t s4_t_r [NPair];
  // stage 5
  q_t s5_e_r, s5_mu_r, s5_p_r;
  q_t s5_s_r [NPair];

  always_comb begin
    g[0]  = grad_x;
    g[1]  = grad_y;
    g[2]  = grad_z;
    gl[0] = glap_x;
    gl[1] = glap_y;
    gl[2] = glap_z;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_phi_r  <= phi;
      s1_phi2_r <= qmul(phi, phi);
      s1_plap_r <= qmul(phi, lap);
      s1_pbil_r <= qmul(phi, bilap);
      s1_lap2_r <= qmul(lap, lap);
      s1_aphi_r <= qmul(coef_a, phi);
      s1_klap_r <= qmul(coef_kappa, lap);
      s1_cbil_r <= qmul(coef_c, bilap);
      for (int k = 0; k < NPair; k++) begin
        s1_gg_r[k] <= qmul(g[PairI[k]], g[PairJ[k]]);
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_ggl_r[i][j] <= qmul(g[i], gl[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_phi3_r  <= qmul(s1_phi2_r, s1_phi_r);
      s2_phi4_r  <= qmul(s1_phi2_r, s1_phi2_r);
      s2_g2_r    <= sat_q(SatW'(s1_gg_r[PairXX]) + SatW'(s1_gg_r[PairYY])
                          + SatW'(s1_gg_r[PairZZ]));
      s2_ggl_r   <= sat_q(SatW'(s1_ggl_r[0][0]) + SatW'(s1_ggl_r[1][1])
                          + SatW'(s1_ggl_r[2][2]));
      s2_aphi_r  <= s1_aphi_r;
      s2_klap_r  <= s1_klap_r;
      s2_cbil_r  <= s1_cbil_r;
      s2_aphi2_r <= qmul(coef_a, s1_phi2_r);
      s2_kplap_r <= qmul(coef_kappa, s1_plap_r);
      s2_cpbil_r <= qmul(coef_c, s1_pbil_r);
      s2_clap2_r <= qmul(coef_c, s1_lap2_r);
      for (int k = 0; k < NPair; k++) begin
        // on the diagonal this is twice the single product
        s2_pair_r[k] <= sat_q(SatW'(s1_ggl_r[PairI[k]][PairJ[k]])
                              + SatW'(s1_ggl_r[PairJ[k]][PairI[k]]));
        s2_kgg_r[k]  <= qmul(coef_kappa, s1_gg_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_bphi3_r <= qmul(coef_b, s2_phi3_r);
      s3_bphi4_r <= qmul(coef_b, s2_phi4_r);
      s3_kg2_r   <= qmul(coef_kappa, s2_g2_r);
      s3_cggl_r  <= qmul(coef_c, s2_ggl_r);
      s3_aphi_r  <= s2_aphi_r;
      s3_klap_r  <= s2_klap_r;
      s3_cbil_r  <= s2_cbil_r;
      s3_aphi2_r <= s2_aphi2_r;
      s3_kplap_r <= s2_kplap_r;
      s3_cpbil_r <= s2_cpbil_r;
      s3_clap2_r <= s2_clap2_r;
      for (int k = 0; k < NPair; k++) begin
        s3_cpair_r[k] <= qmul(coef_c, s2_pair_r[k]);
        s3_kgg_r[k]   <= s2_kgg_r[k];
      end
    end
  end

  // Sums in quarter LSBs: weight 2 for a half, 1 for a quarter, 3 for three quarters.
  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_e_r  <= (ext_acc(s3_aphi2_r) <<< 1) + ext_acc(s3_bphi4_r)
               + (ext_acc(s3_kg2_r) <<< 1) + (ext_acc(s3_clap2_r) <<< 1);
      s4_mu_r <= (ext_acc(s3_aphi_r) <<< 2) + (ext_acc(s3_bphi3_r) <<< 2)
               - (ext_acc(s3_klap_r) <<< 2) + (ext_acc(s3_cbil_r) <<< 2);
      s4_p_r  <= (ext_acc(s3_aphi2_r) <<< 1)
               + (ext_acc(s3_bphi4_r) <<< 1) + ext_acc(s3_bphi4_r)
               - (ext_acc(s3_kplap_r) <<< 2)
               + (ext_acc(s3_kg2_r) <<< 1)
               + (ext_acc(s3_cpbil_r) <<< 2)
               + (ext_acc(s3_clap2_r) <<< 1)
               + (ext_acc(s3_cggl_r) <<< 2);
      for (int k = 0; k < NPair; k++) begin
        s4_t_r[k] <= (ext_acc(s3_kgg_r[k]) <<< 2) - (ext_acc(s3_cpair_r[k]) <<< 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s5_e_r  <= finish(s4_e_r);
      s5_mu_r <= finish(s4_mu_r);
      s5_p_r  <= finish(s4_p_r);
      for (int k = 0; k < NPair; k++) begin
        s5_s_r[k] <= finish(PairDiag[k] ? (s4_p_r + s4_t_r[k]) : s4_t_r[k]);
      end
    end
  end

  assign energy   = s5_e_r;
  assign chem_pot = s5_mu_r;
  assign pressure = s5_p_r;
  assign s_xx     = s5_s_r[PairXX];
  assign s_xy     = s5_s_r[PairXY];
  assign s_xz     = s5_s_r[PairXZ];
  assign s_yy     = s5_s_r[PairYY];
  assign s_yz     = s5_s_r[PairYZ];
  assign s_zz     = s5_s_r[PairZZ];

endmodule

// ===== src/phase_field_stress_kernel_top.sv =====
// Top level of the phase-field free energy and chemical stress kernel.
//
// Usage:
//   Input channel (in_*): one lattice site per beat, nine signed Q16.16 fields.
//   Result channel (out_*): one beat per site with energy density, chemical
//   potential, pressure and the six distinct stress tensor entries, all
//   saturated Q16.16. Results leave in the order sites arrived.
//   Config port (cfg_*): write coef_a, coef_b, coef_kappa, coef_c by index
//   while the pipeline is empty; no read-back.
// Stages and rate:
//   Five register stages; a site accepted at one edge passes through all five
//   and shows on out_*, where it is taken once out_stall is low. One site
//   per cycle sustained while out_stall stays low: every multiplying stage
//   holds its own multipliers, so no unit is shared over cycles.
// Reset (rst_n low, synchronous): clears all stage valid bits and sets the
//   four coefficients to zero.
// Back-pressure: when out_stall holds a result, the output stage holds its
//   beat and stages behind it keep filling bubbles; in_stall rises only once
//   every stage holds a site.
module phase_field_stress_kernel_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [pfsk_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pfsk_pkg::DataW-1:0]    cfg_data,
  // site input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pfsk_pkg::q_t                  in_phi,
  input  pfsk_pkg::q_t                  in_grad_x,
  input  pfsk_pkg::q_t                  in_grad_y,
  input  pfsk_pkg::q_t                  in_grad_z,
  input  pfsk_pkg::q_t                  in_lap,
  input  pfsk_pkg::q_t                  in_bilap,
  input  pfsk_pkg::q_t                  in_glap_x,
  input  pfsk_pkg::q_t                  in_glap_y,
  input  pfsk_pkg::q_t                  in_glap_z,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output pfsk_pkg::q_t                  out_energy,
  output pfsk_pkg::q_t                  out_chem_pot,
  output pfsk_pkg::q_t                  out_pressure,
  output pfsk_pkg::q_t                  out_s_xx,
  output pfsk_pkg::q_t                  out_s_xy,
  output pfsk_pkg::q_t                  out_s_xz,
  output pfsk_pkg::q_t                  out_s_yy,
  output pfsk_pkg::q_t                  out_s_yz,
  output pfsk_pkg::q_t                  out_s_zz
);
  import pfsk_pkg::*;

  q_t coef_a_r, coef_b_r, coef_kappa_r, coef_c_r;
  logic [NStage-1:0] vld_r;
  pipe_ctl_t ctl;

  // Coefficient registers; the datapath reads them directly. The user must write
  // them only while no site is in flight; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= '0;
      coef_b_r     <= '0;
      coef_kappa_r <= '0;
      coef_c_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_A:     coef_a_r     <= cfg_data;
        CFG_COEF_B:     coef_b_r     <= cfg_data;
        CFG_COEF_KAPPA: coef_kappa_r <= cfg_data;
        CFG_COEF_C:     coef_c_r     <= cfg_data;
        default:        coef_a_r     <= coef_a_r;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances, so
  // bubbles collapse behind a stalled output beat.
  always_comb begin
    ctl.en[NStage-1] = !vld_r[NStage-1] || !out_stall;
    for (int k = NStage - 2; k >= 0; k--) begin
      ctl.en[k] = !vld_r[k] || ctl.en[k+1];
    end
  end

  // Valid bits travel alongside the data registers in the core.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ctl.en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NStage; k++) begin
        if (ctl.en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !ctl.en[0];
  assign out_valid = vld_r[NStage-1];

  pfsk_core u_core (
    .clk        (clk),
    .ctl        (ctl),
    .coef_a     (coef_a_r),
    .coef_b     (coef_b_r),
    .coef_kappa (coef_kappa_r),
    .coef_c     (coef_c_r),
    .phi        (in_phi),
    .grad_x     (in_grad_x),
    .grad_y     (in_grad_y),
    .grad_z     (in_grad_z),
    .lap        (in_lap),
    .bilap      (in_bilap),
    .glap_x     (in_glap_x),
    .glap_y     (in_glap_y),
    .glap_z     (in_glap_z),
    .energy     (out_energy),
    .chem_pot   (out_chem_pot),
    .pressure   (out_pressure),
    .s_xx       (out_s_xx),
    .s_xy       (out_s_xy),
    .s_xz       (out_s_xz),
    .s_yy       (out_s_yy),
    .s_yz       (out_s_yz),
    .s_zz       (out_s_zz)
  );

endmodule

// ===== src/pfsk_checker.sv =====
// Port-level checker for the stress kernel, bound to the top level.
module pfsk_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input pfsk_pkg::q_t                  out_energy,
  input pfsk_pkg::q_t                  out_pressure,
  input pfsk_pkg::q_t                  out_s_xx,
  input pfsk_pkg::q_t                  out_s_zz
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_energy)
      && $stable(out_pressure) && $stable(out_s_xx) && $stable(out_s_zz))
    else $error("result beat changed while stalled");

  // Input back-pressure only when the output is blocked with a beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // An accepted site shows on out_valid when the receiver never stalls meanwhile.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind phase_field_stress_kernel_top pfsk_checker u_pfsk_checker (.*);

// ===== sim/tb_phase_field_stress_kernel_top.sv =====
// Self-checking testbench for the phase-field free energy and stress kernel.
module tb_phase_field_stress_kernel_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfsk_pkg::*;

  localparam int N_IN  = 9;
  localparam int N_OUT = 9;

  // Site field positions, in port order.
  localparam int FI_PHI    = 0;
  localparam int FI_GRAD_X = 1;
  localparam int FI_LAP    = 4;
  localparam int FI_BILAP  = 5;
  localparam int FI_GLAP_X = 6;

  // Result field positions: energy, chem_pot, pressure, then xx xy xz yy yz zz.
  localparam int RI_ENERGY   = 0;
  localparam int RI_CHEM_POT = 1;
  localparam int RI_PRESSURE = 2;
  localparam int RI_STRESS   = 3;

  typedef logic [0:N_IN-1][31:0]  site_in_t;
  typedef logic [0:N_OUT-1][31:0] site_out_t;
  typedef logic [0:3][31:0]       coef_set_t;

  localparam logic [31:0] Z     = 32'h0000_0000;
  localparam logic [31:0] QMAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN  = 32'h8000_0000;
  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam logic [31:0] MONE  = 32'hFFFF_0000;
  localparam logic [31:0] HALF  = 32'h0000_8000;
  localparam logic [31:0] MHALF = 32'hFFFF_8000;
  localparam logic [31:0] QTR   = 32'h0000_4000;
  localparam logic [31:0] TWO   = 32'h0002_0000;
  localparam logic [31:0] LSB   = 32'h0000_0001;
  localparam logic [31:0] MLSB  = 32'hFFFF_FFFF;

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;

  // Coefficient settings for the directed part; order a, b, kappa, c.
  localparam logic [2:0] SET_RESET  = 3'd0;
  localparam logic [2:0] SET_UNIT_A = 3'd1;
  localparam logic [2:0] SET_MAX    = 3'd2;
  localparam logic [2:0] SET_MIN    = 3'd3;
  localparam logic [2:0] SET_MIXED  = 3'd4;
  localparam coef_set_t CoefSets [5] = '{
    {Z, Z, Z, Z},
    {ONE, Z, Z, Z},
    {QMAX, QMAX, QMAX, QMAX},
    {QMIN, QMIN, QMIN, QMIN},
    {32'hFFFF_4000, ONE, MHALF, QTR}
  };

  typedef struct packed {
    logic [2:0] cset;
    site_in_t   site;
    logic       has_exp;
    site_out_t  res;
  } dir_row_t;

  // Directed sites. Results are typed in only where they are obvious: with all
  // coefficients zero or all fields zero everything is zero, and with a = 1 alone
  // the energy and pressure are phi^2 / 2 and the chemical potential is phi.
  localparam int DirLen = 21;
  localparam dir_row_t DirTab [DirLen] = '{
    '{SET_RESET, {9{QMAX}}, 1'b1, '0},
    '{SET_RESET, {9{QMIN}}, 1'b1, '0},
    '{SET_RESET, {QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX}, 1'b1, '0},
    '{SET_UNIT_A, {ONE, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1,
      {HALF, ONE, HALF, HALF, Z, Z, HALF, Z, HALF}},
    '{SET_UNIT_A, {MONE, QMAX, QMIN, ONE, QMIN, QMAX, ONE, MONE, QMAX}, 1'b1,
      {HALF, MONE, HALF, HALF, Z, Z, HALF, Z, HALF}},
    '{SET_UNIT_A, {Z, {8{QMAX}}}, 1'b1, '0},
    '{SET_MAX, {9{QMAX}}, 1'b0, '0},
    '{SET_MAX, {9{QMIN}}, 1'b0, '0},
    '{SET_MAX, {9{Z}}, 1'b1, '0},
    '{SET_MAX, {QMAX, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b0, '0},
    '{SET_MAX, {Z, QMIN, QMIN, QMIN, Z, Z, QMAX, QMAX, QMAX}, 1'b0, '0},
    '{SET_MAX, {Z, Z, Z, Z, QMAX, QMIN, Z, Z, Z}, 1'b0, '0},
    '{SET_MIN, {9{QMAX}}, 1'b0, '0},
    '{SET_MIN, {9{QMIN}}, 1'b0, '0},
    '{SET_MIN, {MONE, QMAX, Z, Z, ONE, Z, Z, QMIN, Z}, 1'b0, '0},
    '{SET_MIN, {LSB, {8{MLSB}}}, 1'b0, '0},
    '{SET_MIXED, {ONE, HALF, MONE, TWO, 32'h0001_8000, 32'hFFFE_0000, QTR,
      32'hFFFF_C000, ONE}, 1'b0, '0},
    '{SET_MIXED, {MHALF, TWO, QTR, MHALF, MONE, HALF, TWO, MONE, QTR}, 1'b0, '0},
    '{SET_MIXED, {32'h0002_8000, MONE, MONE, MONE, TWO, TWO, MHALF, MHALF, MHALF},
      1'b0, '0},
    '{SET_MIXED, {9{LSB}}, 1'b0, '0},
    '{SET_MIXED, {9{MLSB}}, 1'b0, '0}
  };

  localparam int RandPhases    = 8;
  localparam int SitesPerPhase = 135;
  localparam int QuietFrom     = 400;   // no idling on either side in this window
  localparam int QuietTo       = 600;
  localparam int HoldAfter     = 300;   // results seen before the long hold-off
  localparam int HoldCycles    = 80;
  localparam int DrainCycles   = 20;
  localparam int CycleLimit    = 200000;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  q_t       cfg_data;
  logic     in_valid;
  logic     in_stall;
  q_t       in_phi, in_grad_x, in_grad_y, in_grad_z, in_lap, in_bilap;
  q_t       in_glap_x, in_glap_y, in_glap_z;
  logic     out_valid;
  logic     out_stall;
  q_t       out_energy, out_chem_pot, out_pressure;
  q_t       out_s_xx, out_s_xy, out_s_xz, out_s_yy, out_s_yz, out_s_zz;

  // Predictor copy of the coefficient registers.
  q_t coef_now [4];

  site_out_t stress_q [$];   // expected results, oldest first

  int n_err;
  int sites_sent;
  int beats_seen;
  int sat_seen;
  int sets_loaded;
  int cyc;

  string res_name [N_OUT] = '{"energy", "chem_pot", "pressure",
                              "s_xx", "s_xy", "s_xz", "s_yy", "s_yz", "s_zz"};

  phase_field_stress_kernel_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_phi       (in_phi),
    .in_grad_x    (in_grad_x),
    .in_grad_y    (in_grad_y),
    .in_grad_z    (in_grad_z),
    .in_lap       (in_lap),
    .in_bilap     (in_bilap),
    .in_glap_x    (in_glap_x),
    .in_glap_y    (in_glap_y),
    .in_glap_z    (in_glap_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_energy   (out_energy),
    .out_chem_pot (out_chem_pot),
    .out_pressure (out_pressure),
    .out_s_xx     (out_s_xx),
    .out_s_xy     (out_s_xy),
    .out_s_xz     (out_s_xz),
    .out_s_yy     (out_s_yy),
    .out_s_yz     (out_s_yz),
    .out_s_zz     (out_s_zz)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor. Every term is a rounded, clamped Q16.16 product;
  // the sums are kept exact in quarter LSBs and rounded once at the end.
  // ---------------------------------------------------------------------------
  function automatic longint clamp_q(input longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  // Round half up, floor shift, clamp.
  function automatic longint qprod(input longint x, input longint y);
    longint p;
    p = x * y + 64'sd32768;
    return clamp_q(p >>> 16);
  endfunction

  // Quarter-LSB sum back to Q16.16.
  function automatic logic [31:0] quarter_to_q(input longint acc);
    longint t;
    t = clamp_q((acc + 2) >>> 2);
    return t[31:0];
  endfunction

  function automatic site_out_t stress_of_site(input site_in_t s);
    longint    phi, lap, bilap, ca, cb, ck, cc;
    longint    g [3];
    longint    gl [3];
    longint    phi2, phi3, phi4, g2, lap2, ggl;
    longint    e_acc, mu_acc, p_acc, acc, pair;
    site_out_t r;
    int        i, j, k;
    phi   = $signed(s[FI_PHI]);
    lap   = $signed(s[FI_LAP]);
    bilap = $signed(s[FI_BILAP]);
    for (i = 0; i < 3; i++) begin
      g[i]  = $signed(s[FI_GRAD_X + i]);
      gl[i] = $signed(s[FI_GLAP_X + i]);
    end
    ca = coef_now[CFG_COEF_A];
    cb = coef_now[CFG_COEF_B];
    ck = coef_now[CFG_COEF_KAPPA];
    cc = coef_now[CFG_COEF_C];

    phi2 = qprod(phi, phi);
    phi3 = qprod(phi2, phi);
    phi4 = qprod(phi2, phi2);
    lap2 = qprod(lap, lap);
    g2   = clamp_q(qprod(g[0], g[0]) + qprod(g[1], g[1]) + qprod(g[2], g[2]));
    ggl  = clamp_q(qprod(g[0], gl[0]) + qprod(g[1], gl[1]) + qprod(g[2], gl[2]));

    // Weights in quarters: 0.5 -> 2, 0.25 -> 1, 0.75 -> 3, 1 -> 4.
    e_acc  = 2 * qprod(ca, phi2) + qprod(cb, phi4)
           + 2 * qprod(ck, g2) + 2 * qprod(cc, lap2);
    mu_acc = 4 * qprod(ca, phi) + 4 * qprod(cb, phi3)
           - 4 * qprod(ck, lap) + 4 * qprod(cc, bilap);
    p_acc  = 2 * qprod(ca, phi2) + 3 * qprod(cb, phi4)
           - 4 * qprod(ck, qprod(phi, lap))
           + 2 * qprod(ck, g2)
           + 4 * qprod(cc, qprod(phi, bilap))
           + 2 * qprod(cc, lap2)
           + 4 * qprod(cc, ggl);

    r[RI_ENERGY]   = quarter_to_q(e_acc);
    r[RI_CHEM_POT] = quarter_to_q(mu_acc);
    r[RI_PRESSURE] = quarter_to_q(p_acc);

    // Upper triangle in xx xy xz yy yz zz order; diagonal starts from exact p0.
    k = RI_STRESS;
    for (i = 0; i < 3; i++) begin
      for (j = i; j < 3; j++) begin
        pair = clamp_q(qprod(g[i], gl[j]) + qprod(g[j], gl[i]));
        acc  = (i == j) ? p_acc : 64'sd0;
        acc  = acc + 4 * qprod(ck, qprod(g[i], g[j])) - 4 * qprod(cc, pair);
        r[k] = quarter_to_q(acc);
        k++;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values. Mostly moderate magnitudes so results stay off the rails;
  // now and then full-range words and the extremes.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_field(input int mode);
    int sel;
    sel = (mode == 2) ? int'($urandom_range(0, 15)) : 8;
    if (sel == 0) return QMAX;
    if (sel == 1) return QMIN;
    if (sel == 2) return Z;
    if (sel < 6 || mode == 1) return $urandom;
    // +/- 8.0 with a random fraction
    return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  function automatic logic [31:0] pick_coef(input int ph);
    int sel;
    sel = $urandom_range(0, 3);
    if (ph % 4 == 0) return $urandom;
    if (ph % 4 == 3) return $urandom_range(0, 1) ? QMAX : QMIN;
    if (sel == 0) return Z;
    // +/- 2.0
    return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one site; return at the edge that accepts it, with its expected
  // result queued (typed in, or from the predictor).
  task automatic send_site(input site_in_t s, input logic has_exp, input site_out_t typed);
    @(negedge clk);
    // Idle at random, except inside the quiet window.
    while (!(sites_sent >= QuietFrom && sites_sent < QuietTo)
           && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_phi    <= s[FI_PHI];
    in_grad_x <= s[FI_GRAD_X];
    in_grad_y <= s[FI_GRAD_X + 1];
    in_grad_z <= s[FI_GRAD_X + 2];
    in_lap    <= s[FI_LAP];
    in_bilap  <= s[FI_BILAP];
    in_glap_x <= s[FI_GLAP_X];
    in_glap_y <= s[FI_GLAP_X + 1];
    in_glap_z <= s[FI_GLAP_X + 2];
    // Hold the beat until the block takes it.
    do @(posedge clk); while (in_stall);
    stress_q.push_back(has_exp ? typed : stress_of_site(s));
    sites_sent++;
  endtask

  // Drain the pipeline, then write all four coefficients back to back.
  task automatic apply_coefs(input coef_set_t c);
    cfg_idx_t r;
    @(negedge clk);
    in_valid <= 1'b0;
    while (stress_q.size() != 0) @(negedge clk);
    r = CFG_COEF_A;
    repeat (4) begin
      cfg_we      <= 1'b1;
      cfg_index   <= r;
      cfg_data    <= c[r];
      coef_now[r] = c[r];
      @(negedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    sets_loaded++;
  endtask

  initial begin : stimulus
    site_in_t   s;
    coef_set_t  c;
    logic [2:0] cur_set;
    int         row, ph, n, f, mode;

    // Known values on every input from time zero.
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_COEF_A;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_phi    = '0;
    in_grad_x = '0;
    in_grad_y = '0;
    in_grad_z = '0;
    in_lap    = '0;
    in_bilap  = '0;
    in_glap_x = '0;
    in_glap_y = '0;
    in_glap_z = '0;
    foreach (coef_now[i]) coef_now[i] = '0;
    n_err       = 0;
    sites_sent  = 0;
    sets_loaded = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reload coefficients whenever the table moves to a new set.
    cur_set = SET_RESET;
    for (row = 0; row < DirLen; row++) begin
      if (DirTab[row].cset != cur_set) begin
        cur_set = DirTab[row].cset;
        apply_coefs(CoefSets[cur_set]);
      end
      send_site(DirTab[row].site, DirTab[row].has_exp, DirTab[row].res);
    end

    // Random part: a fresh coefficient setting per phase.
    for (ph = 0; ph < RandPhases; ph++) begin
      for (f = 0; f < 4; f++) c[f] = pick_coef(ph);
      apply_coefs(c);
      for (n = 0; n < SitesPerPhase; n++) begin
        // 0: all moderate, 1: all full range, 2: mixed per field
        mode = $urandom_range(0, 9);
        mode = (mode < 7) ? 0 : (mode == 7) ? 1 : 2;
        for (f = 0; f < N_IN; f++) s[f] = pick_field(mode);
        send_site(s, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (stress_q.size() != 0) @(posedge clk);
    // Allow a few pipeline depths for any stray beat to show up.
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d sites over %0d coefficient settings plus reset values;",
             sites_sent, sets_loaded);
    $display("%0d results checked, %0d fields landed on a Q16.16 rail",
             beats_seen, sat_seen);
    if (n_err == 0) begin
      $display("tb_phase_field_stress_kernel_top passed");
    end else begin
      $display("tb_phase_field_stress_kernel_top failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, a quiet window, and one long hold-off while
  // the sender keeps offering, so the pipeline fills and in_stall rises.
  // ---------------------------------------------------------------------------
  initial begin : result_stall
    int  hold_left;
    logic hold_done;
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && beats_seen >= HoldAfter && in_valid) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(beats_seen >= QuietFrom && beats_seen < QuietTo)
                     && $urandom_range(0, 99) < 16;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each accepted beat field by field with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  initial begin
    beats_seen = 0;
    sat_seen   = 0;
  end

  always @(posedge clk) begin : result_check
    site_out_t got;
    site_out_t want;
    int        k;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = {out_energy, out_chem_pot, out_pressure,
             out_s_xx, out_s_xy, out_s_xz, out_s_yy, out_s_yz, out_s_zz};
      beats_seen++;
      if (stress_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, energy %h", $time, got[RI_ENERGY]);
        n_err++;
      end else begin
        want = stress_q.pop_front();
        for (k = 0; k < N_OUT; k++) begin
          if (got[k] === QMAX || got[k] === QMIN) sat_seen++;
          if (got[k] !== want[k]) begin
            $display("%0t: %s expected %h actual %h", $time, res_name[k], want[k], got[k]);
            n_err++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial cyc = 0;
  always @(posedge clk) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, stress_q.size());
      $display("tb_phase_field_stress_kernel_top failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
src/pfsk_pkg.sv
src/pfsk_core.sv
src/phase_field_stress_kernel_top.sv
src/pfsk_checker.sv
sim/tb_phase_field_stress_kernel_top.sv
